FILE: rtl/pip_pkg.sv
// shared types, sizes and helpers for the point in polygon test block
// no dependencies; imported by every module of the block
`default_nettype none

package pip_pkg;

  // vertex store size and the widths that follow from it
  localparam int MAX_VERTICES = 64;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int VCOUNT_W     = $clog2(MAX_VERTICES + 1);
  localparam int ISSUE_W      = $clog2(MAX_VERTICES + 3);

  // coordinate and tolerance widths
  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int EPS_W   = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

  // saturation limits
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // raw mode codes of an input item
  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_APPEND = 2'd1;
  localparam logic [1:0] MODE_XLATE  = 2'd2;
  localparam logic [1:0] MODE_QUERY  = 2'd3;

  // decoded operation
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_XLATE  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  // input item payload
  typedef struct packed {
    logic [1:0]               mode;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } item_t;

  // result item payload
  typedef struct packed {
    logic                inside_res;
    logic [VCOUNT_W-1:0] vertex_count;
    logic                status;
  } result_t;

  // classified command held in the queue
  typedef struct packed {
    op_t                       op;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } cmd_t;

  // one stored vertex
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vertex_t;

  // sign extend a coordinate by one bit
  function automatic logic signed [DIFF_W-1:0] sx(input logic [COORD_W-1:0] v);
    sx = $signed({v[COORD_W-1], v});
  endfunction

  // magnitude of a one bit wider difference
  function automatic logic signed [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    mag = v[DIFF_W-1] ? -v : v;
  endfunction

  // saturating add of an offset to a coordinate
  function automatic logic signed [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                         input logic [COORD_W-1:0] b);
    logic signed [DIFF_W-1:0] s;
    s = sx(a) + sx(b);
    if (s[DIFF_W-1] != s[DIFF_W-2]) begin
      sat_add = s[DIFF_W-1] ? COORD_MIN : COORD_MAX;
    end else begin
      sat_add = s[COORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pip_front.sv
// front end: accepts input items, decodes the mode, queues commands
// depends on pip_pkg
`default_nettype none

module pip_front import pip_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t item,
  input  wire logic  item_valid,
  output logic       item_ready,
  output cmd_t       cmd,
  output logic       cmd_valid,
  input  wire logic  cmd_ready
);

  cmd_t               q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;
  cmd_t               decoded;
  logic               push;
  logic               pop;

  // classify the incoming item
  always_comb begin
    decoded.x = item.coord_x;
    decoded.y = item.coord_y;
    case (item.mode)
      MODE_CLEAR:  decoded.op = OP_CLEAR;
      MODE_APPEND: decoded.op = OP_APPEND;
      MODE_XLATE:  decoded.op = OP_XLATE;
      MODE_QUERY:  decoded.op = OP_QUERY;
      default:     decoded.op = OP_QUERY;
    endcase
  end

  // handshakes
  assign item_ready = (fill != QFILL_W'(QUEUE_DEPTH));
  assign cmd_valid  = (fill != '0);
  assign push       = item_valid && item_ready;
  assign pop        = cmd_valid && cmd_ready;
  assign cmd        = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= decoded;
    end
  end

  // queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pip_back.sv
// back end: vertex store, translate sweep and query edge walk
// depends on pip_pkg; fed by pip_front through the command queue
`default_nettype none

module pip_back import pip_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [EPS_W-1:0] epsilon,
  input  wire cmd_t             cmd,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  output result_t               result,
  output logic                  result_valid,
  input  wire logic             result_ready
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WALK  = 3'b010,
    ST_XLATE = 3'b100
  } state_t;

  state_t              state;
  logic [VCOUNT_W-1:0] count;
  logic [ADDR_W-1:0]   raddr;
  logic [ADDR_W-1:0]   last_addr;
  logic [ADDR_W-1:0]   wb_addr;
  logic [ISSUE_W-1:0]  issue_left;
  logic                rvalid;
  logic [1:0]          fill;
  logic                e0_valid;
  logic                s1_valid;
  logic                s2_valid;
  logic                parity;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  logic signed [COORD_W-1:0] ox;
  logic signed [COORD_W-1:0] oy;

  vertex_t vmem [MAX_VERTICES];
  vertex_t rd_data;
  vertex_t prv;
  vertex_t cur;
  vertex_t nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  vertex_t           mem_wdata;
  logic              rd_en;
  logic              pop;
  logic              busy_done;

  // edge pipeline registers
  logic                     s1_meets;
  logic                     s1_flat;
  logic                     s1_flathit;
  logic                     s1_cnt;
  logic signed [DIFF_W-1:0] s1_ma;
  logic signed [DIFF_W-1:0] s1_mb;
  logic signed [DIFF_W-1:0] s1_mc;
  logic signed [DIFF_W-1:0] s1_md;
  logic                     s2_meets;
  logic                     s2_flat;
  logic                     s2_flathit;
  logic                     s2_cnt;
  logic signed [PROD_W-1:0] s2_p1;
  logic signed [PROD_W-1:0] s2_p2;

  // edge classification signals
  vertex_t                  lo;
  vertex_t                  hi;
  logic                     swap;
  logic                     meets;
  logic signed [DIFF_W-1:0] eps_s;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] d1;
  logic signed [DIFF_W-1:0] d2;
  logic signed [DIFF_W-1:0] adx;
  logic                     flat;
  logic                     cnt;
  logic signed [PROD_W:0]   cross_sum;
  logic                     edge_hit;

  // take a command only when idle and the result slot is free
  assign cmd_ready = (state == ST_IDLE) && (!result_valid || result_ready);
  assign pop       = cmd_valid && cmd_ready;
  assign rd_en     = (state != ST_IDLE) && (issue_left != '0);
  assign busy_done = (issue_left == '0) && !rvalid && !e0_valid && !s1_valid && !s2_valid;

  // memory write source: append at pop, translate write-back on read data
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[ADDR_W-1:0];
    mem_wdata.x = cmd.x;
    mem_wdata.y = cmd.y;
    if (pop && cmd.op == OP_APPEND && count < VCOUNT_W'(MAX_VERTICES)) begin
      mem_we = 1'b1;
    end else if (state == ST_XLATE && rvalid) begin
      mem_we      = 1'b1;
      mem_waddr   = wb_addr;
      mem_wdata.x = sat_add(rd_data.x, ox);
      mem_wdata.y = sat_add(rd_data.y, oy);
    end
  end

  // vertex store with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      vmem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data <= vmem[raddr];
    end
  end

  // stage 0: classify the edge cur -> nxt against the ray
  always_comb begin
    eps_s = $signed({{(DIFF_W-EPS_W){1'b0}}, epsilon});
    swap  = !(cur.y < nxt.y);
    lo    = swap ? nxt : cur;
    hi    = swap ? cur : nxt;
    meets = (hi.y >= py) && (lo.y <= py);
    dy    = sx(hi.y) - sx(lo.y);
    flat  = (dy < eps_s) || (dy == '0);
    d1    = mag(sx(cur.y) - sx(py));
    d2    = mag(sx(nxt.y) - sx(py));
    adx   = mag(sx(cur.x) - sx(px));
    if (d1 > eps_s && d2 > eps_s) begin
      cnt = 1'b1;
    end else if (d1 < eps_s) begin
      cnt = ((cur.y < prv.y) != (cur.y < nxt.y)) || (adx < eps_s);
    end else begin
      cnt = 1'b0;
    end
  end

  // stage 2: sign of the cross-multiplied interpolation
  assign cross_sum = $signed({s2_p1[PROD_W-1], s2_p1}) + $signed({s2_p2[PROD_W-1], s2_p2});
  assign edge_hit  = s2_meets && s2_cnt && (s2_flat ? s2_flathit : !cross_sum[PROD_W]);

  // edge pipeline payload
  always_ff @(posedge clk) begin
    s1_meets   <= meets;
    s1_flat    <= flat;
    s1_flathit <= (cur.x >= px);
    s1_cnt     <= cnt;
    s1_ma      <= sx(lo.x) - sx(px);
    s1_mb      <= dy;
    s1_mc      <= sx(py) - sx(lo.y);
    s1_md      <= sx(hi.x) - sx(lo.x);
    s2_meets   <= s1_meets;
    s2_flat    <= s1_flat;
    s2_flathit <= s1_flathit;
    s2_cnt     <= s1_cnt;
    s2_p1      <= s1_ma * s1_mb;
    s2_p2      <= s1_mc * s1_md;
  end

  // vertex window: prev, current, next; also the command point, offset and result
  always_ff @(posedge clk) begin
    if (state == ST_WALK && rvalid) begin
      prv <= cur;
      cur <= nxt;
      nxt <= rd_data;
    end
    if (pop) begin
      px <= cmd.x;
      py <= cmd.y;
      ox <= cmd.x;
      oy <= cmd.y;
    end
    if (pop) begin
      result.inside_res   <= 1'b0;
      result.status       <= 1'b0;
      result.vertex_count <= count;
      case (cmd.op)
        OP_CLEAR: begin
          result.vertex_count <= '0;
        end
        OP_APPEND: begin
          if (count < VCOUNT_W'(MAX_VERTICES)) begin
            result.vertex_count <= count + 1'b1;
          end else begin
            result.status <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end else if (state == ST_WALK && busy_done) begin
      result.inside_res <= parity;
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      raddr        <= '0;
      last_addr    <= '0;
      wb_addr      <= '0;
      issue_left   <= '0;
      rvalid       <= 1'b0;
      fill         <= '0;
      e0_valid     <= 1'b0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      parity       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      rvalid   <= rd_en;
      e0_valid <= (state == ST_WALK) && rvalid && (fill >= 2'd2);
      s1_valid <= e0_valid;
      s2_valid <= s1_valid;
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (rd_en) begin
        issue_left <= issue_left - 1'b1;
        raddr      <= (raddr == last_addr) ? '0 : raddr + 1'b1;
      end
      if (state == ST_WALK && rvalid && fill != 2'd3) begin
        fill <= fill + 1'b1;
      end
      if (edge_hit && s2_valid) begin
        parity <= !parity;
      end
      if (state == ST_XLATE && rvalid) begin
        wb_addr <= wb_addr + 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (pop) begin
            last_addr <= ADDR_W'(count - 1'b1);
            wb_addr   <= '0;
            fill      <= '0;
            parity    <= 1'b0;
            case (cmd.op)
              OP_CLEAR: begin
                count        <= '0;
                result_valid <= 1'b1;
              end
              OP_APPEND: begin
                if (count < VCOUNT_W'(MAX_VERTICES)) begin
                  count <= count + 1'b1;
                end
                result_valid <= 1'b1;
              end
              OP_XLATE: begin
                if (count == '0) begin
                  result_valid <= 1'b1;
                end else begin
                  state      <= ST_XLATE;
                  raddr      <= '0;
                  issue_left <= ISSUE_W'(count);
                end
              end
              OP_QUERY: begin
                if (count == '0) begin
                  result_valid <= 1'b1;
                end else begin
                  state      <= ST_WALK;
                  raddr      <= ADDR_W'(count - 1'b1);
                  issue_left <= ISSUE_W'(count) + ISSUE_W'(2);
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_WALK, ST_XLATE: begin
          if (busy_done) begin
            state        <= ST_IDLE;
            result_valid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/point_in_polygon_test.sv
// top level of the point in polygon test block: epsilon register and wiring
// depends on pip_pkg, pip_front and pip_back
`default_nettype none

// Keeps up to MAX_VERTICES polygon vertices and answers one result per item.
// Clear and append need no memory read; translate and query walk the stored
// vertices through the single read port of the vertex memory, which delivers
// one vertex per cycle, and a query feeds them through the three stage edge
// pipeline behind it. A two entry command queue lets new items be accepted
// while the back end works or a result waits. Epsilon is written through
// cfg_we and cfg_wdata and resets to 1; the user must write it only while the
// block is idle, which the block itself does not enforce.
module point_in_polygon_test import pip_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire item_t            item,
  input  wire logic             item_valid,
  output logic                  item_ready,
  output result_t               result,
  output logic                  result_valid,
  input  wire logic             result_ready,
  input  wire logic             cfg_we,
  input  wire logic [EPS_W-1:0] cfg_wdata
);

  logic [EPS_W-1:0] epsilon;
  cmd_t             cmd;
  logic             cmd_valid;
  logic             cmd_ready;

  // tolerance register
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_RESET;
    end else if (cfg_we) begin
      epsilon <= cfg_wdata;
    end
  end

  // item intake and queue
  pip_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready)
  );

  // store and execution
  pip_back u_back (
    .clk          (clk),
    .rst          (rst),
    .epsilon      (epsilon),
    .cmd          (cmd),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

`default_nettype wire
